// ----- hdl/lru_block_buffer_cache_assert.svh -----
// ---------------------------------------------------------------------------
// lru_block_buffer_cache_assert.svh
// Assertion macros shared by the buffer cache checker.
// ---------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH
`define LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define LBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buffer cache assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define LBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buffer cache assertion failed");

`endif

// ----- hdl/lbc_pkg.sv -----
// ---------------------------------------------------------------------------
// lbc_pkg
// Widths, codes and shared structures of the LRU block buffer cache.
// ---------------------------------------------------------------------------
package lbc_pkg;

  localparam int SLOTS_DEFAULT = 32;

  localparam int OP_W   = 2;
  localparam int DEV_W  = 8;
  localparam int BLK_W  = 32;
  localparam int SLOT_W = 5;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 8;
  localparam int CMP_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_TOP = 8'd255;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_GET     = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;
  localparam logic [OP_W-1:0] OP_IODONE  = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOBUF = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOREF = 2'd2;

  // Modes of the shared compare unit.
  localparam logic [CMP_W-1:0] CMP_HIT  = 2'd0;
  localparam logic [CMP_W-1:0] CMP_FREE = 2'd1;
  localparam logic [CMP_W-1:0] CMP_AGE  = 2'd2;

  // One slot entry as seen on the store read port.
  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] cnt;
    logic             valid;
    logic             dirty;
  } lbc_rd_t;

  // Write controls and data for the store write port.
  typedef struct packed {
    logic             we_tag;
    logic             we_cnt;
    logic             we_rank;
    logic             set_valid;
    logic             clr_valid;
    logic             set_dirty;
    logic             clr_dirty;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] cnt;
  } lbc_wr_t;

  // One result.
  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              hit;
    logic              needs_read;
    logic [STAT_W-1:0] status;
  } lbc_res_t;

endpackage

// ----- hdl/lbc_store.sv -----
// ---------------------------------------------------------------------------
// lbc_store
// Slot state memories with one read and one write address per cycle.
// ---------------------------------------------------------------------------
module lbc_store #(
  parameter int SLOTS = lbc_pkg::SLOTS_DEFAULT,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IW-1:0]    raddr,
  input  logic [IW-1:0]    waddr,
  input  lbc_pkg::lbc_wr_t wr,
  input  logic [IW-1:0]    wrank,
  output lbc_pkg::lbc_rd_t rd,
  output logic [IW-1:0]    rd_rank,
  output logic [IW-1:0]    rd_addr
);
  import lbc_pkg::*;

  logic [DEV_W-1:0] mem_dev  [SLOTS];
  logic [BLK_W-1:0] mem_blk  [SLOTS];
  logic [CNT_W-1:0] mem_cnt  [SLOTS];
  logic [IW-1:0]    mem_rank [SLOTS];

  // A clear written flag makes an entry read as its reset value.
  logic [SLOTS-1:0] tag_wr;
  logic [SLOTS-1:0] cnt_wr;
  logic [SLOTS-1:0] rank_wr;
  logic [SLOTS-1:0] valid_v;
  logic [SLOTS-1:0] dirty_v;

  logic [DEV_W-1:0] dev_q;
  logic [BLK_W-1:0] blk_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IW-1:0]    rank_q;
  logic [IW-1:0]    raddr_q;

  always_ff @(posedge clk) begin
    if (wr.we_tag) begin
      mem_dev[waddr] <= wr.dev;
      mem_blk[waddr] <= wr.blk;
    end
    if (wr.we_cnt) begin
      mem_cnt[waddr] <= wr.cnt;
    end
    if (wr.we_rank) begin
      mem_rank[waddr] <= wrank;
    end
    dev_q  <= mem_dev[raddr];
    blk_q  <= mem_blk[raddr];
    cnt_q  <= mem_cnt[raddr];
    rank_q <= mem_rank[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_wr  <= '0;
      cnt_wr  <= '0;
      rank_wr <= '0;
      valid_v <= '0;
      dirty_v <= '0;
      raddr_q <= '0;
    end else begin
      raddr_q <= raddr;
      if (wr.we_tag) begin
        tag_wr[waddr] <= 1'b1;
      end
      if (wr.we_cnt) begin
        cnt_wr[waddr] <= 1'b1;
      end
      if (wr.we_rank) begin
        rank_wr[waddr] <= 1'b1;
      end
      if (wr.set_valid) begin
        valid_v[waddr] <= 1'b1;
      end else if (wr.clr_valid) begin
        valid_v[waddr] <= 1'b0;
      end
      if (wr.set_dirty) begin
        dirty_v[waddr] <= 1'b1;
      end else if (wr.clr_dirty) begin
        dirty_v[waddr] <= 1'b0;
      end
    end
  end

  always_comb begin
    rd.dev   = tag_wr[raddr_q] ? dev_q : '0;
    rd.blk   = tag_wr[raddr_q] ? blk_q : '0;
    rd.cnt   = cnt_wr[raddr_q] ? cnt_q : '0;
    rd.valid = valid_v[raddr_q];
    rd.dirty = dirty_v[raddr_q];
    rd_rank  = rank_wr[raddr_q] ? rank_q : raddr_q;
    rd_addr  = raddr_q;
  end

endmodule

// ----- hdl/lbc_cmp.sv -----
// ---------------------------------------------------------------------------
// lbc_cmp
// Shared compare unit: judges one slot entry against the running best.
// ---------------------------------------------------------------------------
module lbc_cmp #(
  parameter int SLOTS = lbc_pkg::SLOTS_DEFAULT,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic [lbc_pkg::CMP_W-1:0] mode,
  input  lbc_pkg::lbc_rd_t          rd,
  input  logic [IW-1:0]             rd_rank,
  input  logic [lbc_pkg::DEV_W-1:0] key_dev,
  input  logic [lbc_pkg::BLK_W-1:0] key_blk,
  input  logic [IW-1:0]             ref_rank,
  input  logic                      found,
  output logic                      take
);
  import lbc_pkg::*;

  logic newer;
  logic older;

  assign newer = rd_rank > ref_rank;
  assign older = rd_rank < ref_rank;

  always_comb begin
    case (mode)
      CMP_HIT:  take = (rd.dev == key_dev) && (rd.blk == key_blk) && (!found || newer);
      CMP_FREE: take = (rd.cnt == '0) && !rd.dirty && (!found || older);
      CMP_AGE:  take = newer;
      default:  take = 1'b0;
    endcase
  end

endmodule

// ----- hdl/lbc_seq.sv -----
// ---------------------------------------------------------------------------
// lbc_seq
// Sequencer: walks the slots through the shared compare unit per request.
// ---------------------------------------------------------------------------
module lbc_seq #(
  parameter int SLOTS = lbc_pkg::SLOTS_DEFAULT,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lbc_pkg::OP_W-1:0]   in_op,
  input  logic [lbc_pkg::DEV_W-1:0]  in_dev,
  input  logic [lbc_pkg::BLK_W-1:0]  in_blk,
  input  logic [lbc_pkg::SLOT_W-1:0] in_slot,
  output logic                       res_valid,
  input  logic                       res_ready,
  output lbc_pkg::lbc_res_t          res,
  output logic [IW-1:0]              raddr,
  output logic [IW-1:0]              waddr,
  output lbc_pkg::lbc_wr_t           wr,
  output logic [IW-1:0]              wrank,
  input  lbc_pkg::lbc_rd_t           rd,
  input  logic [IW-1:0]              rd_rank,
  input  logic [IW-1:0]              rd_addr
);
  import lbc_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LAST     = CW'(SLOTS);
  localparam logic [IW-1:0] TOP_RANK = IW'(SLOTS - 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SCAN_HIT  = 4'd1;
  localparam logic [3:0] S_HIT_RD    = 4'd2;
  localparam logic [3:0] S_HIT_WR    = 4'd3;
  localparam logic [3:0] S_SCAN_FREE = 4'd4;
  localparam logic [3:0] S_SLOT_RD   = 4'd5;
  localparam logic [3:0] S_CHECK     = 4'd6;
  localparam logic [3:0] S_SWEEP     = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0]        state, state_next;
  logic [CW-1:0]     idx, idx_next;
  logic              found, found_next;
  logic [IW-1:0]     best, best_next;
  logic [IW-1:0]     best_rank, best_rank_next;
  logic [IW-1:0]     old_rank, old_rank_next;
  lbc_res_t          res_r, res_next;
  logic [OP_W-1:0]   op;
  logic [DEV_W-1:0]  dev;
  logic [BLK_W-1:0]  blk;
  logic [SLOT_W-1:0] slot_in;

  logic              accept;
  logic              in_range;
  logic [IW-1:0]     slot_idx;
  logic              scan_cmp;
  logic              take;
  logic [CMP_W-1:0]  cmp_mode;
  logic [IW-1:0]     ref_rank;
  logic              found_n;
  logic [IW-1:0]     best_n;
  logic [IW-1:0]     best_rank_n;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_DONE);
  assign res       = res_r;
  assign in_range  = int'(in_slot) < SLOTS;
  assign slot_idx  = IW'(slot_in);

  // Read data in a scan belongs to the entry issued in the cycle before.
  assign scan_cmp    = (idx != '0);
  assign cmp_mode    = (state == S_SCAN_HIT)  ? CMP_HIT :
                       (state == S_SCAN_FREE) ? CMP_FREE : CMP_AGE;
  assign ref_rank    = (state == S_SWEEP) ? old_rank : best_rank;
  assign found_n     = found || (scan_cmp && take);
  assign best_n      = (scan_cmp && take) ? rd_addr : best;
  assign best_rank_n = (scan_cmp && take) ? rd_rank : best_rank;

  lbc_cmp #(.SLOTS(SLOTS)) u_cmp (
    .mode     (cmp_mode),
    .rd       (rd),
    .rd_rank  (rd_rank),
    .key_dev  (dev),
    .key_blk  (blk),
    .ref_rank (ref_rank),
    .found    (found),
    .take     (take)
  );

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    found_next     = found;
    best_next      = best;
    best_rank_next = best_rank;
    old_rank_next  = old_rank;
    res_next       = res_r;
    raddr          = (idx == LAST) ? '0 : IW'(idx);
    waddr          = slot_idx;
    wrank          = TOP_RANK;
    wr             = '0;
    wr.dev         = dev;
    wr.blk         = blk;
    case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next   = '0;
          found_next = 1'b0;
          if (in_op == OP_GET) begin
            state_next = S_SCAN_HIT;
          end else if (!in_range) begin
            res_next   = '{slot_out: in_slot, hit: 1'b0, needs_read: 1'b0, status: ST_NOREF};
            state_next = S_DONE;
          end else if (in_op == OP_IODONE) begin
            waddr        = IW'(in_slot);
            wr.set_valid = 1'b1;
            wr.clr_dirty = 1'b1;
            res_next     = '{slot_out: in_slot, hit: 1'b0, needs_read: 1'b0, status: ST_OK};
            state_next   = S_DONE;
          end else begin
            state_next = S_SLOT_RD;
          end
        end
      end
      S_SCAN_HIT: begin
        idx_next       = idx + CW'(1);
        found_next     = found_n;
        best_next      = best_n;
        best_rank_next = best_rank_n;
        if (idx == LAST) begin
          if (found_n) begin
            state_next = S_HIT_RD;
          end else begin
            idx_next   = '0;
            found_next = 1'b0;
            state_next = S_SCAN_FREE;
          end
        end
      end
      S_HIT_RD: begin
        raddr      = best;
        state_next = S_HIT_WR;
      end
      S_HIT_WR: begin
        waddr     = best;
        wr.we_cnt = 1'b1;
        wr.cnt    = (rd.cnt == COUNT_TOP) ? rd.cnt : rd.cnt + CNT_W'(1);
        res_next  = '{slot_out: SLOT_W'(best), hit: 1'b1, needs_read: !rd.valid,
                      status: ST_OK};
        state_next = S_DONE;
      end
      S_SCAN_FREE: begin
        idx_next       = idx + CW'(1);
        found_next     = found_n;
        best_next      = best_n;
        best_rank_next = best_rank_n;
        if (idx == LAST) begin
          if (found_n) begin
            waddr        = best_n;
            wr.we_tag    = 1'b1;
            wr.we_cnt    = 1'b1;
            wr.cnt       = CNT_W'(1);
            wr.clr_valid = 1'b1;
            wr.clr_dirty = 1'b1;
            res_next     = '{slot_out: SLOT_W'(best_n), hit: 1'b0, needs_read: 1'b1,
                             status: ST_OK};
          end else begin
            res_next = '{slot_out: '0, hit: 1'b0, needs_read: 1'b0, status: ST_NOBUF};
          end
          state_next = S_DONE;
        end
      end
      S_SLOT_RD: begin
        raddr      = slot_idx;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        res_next   = '{slot_out: slot_in, hit: 1'b0, needs_read: 1'b0, status: ST_OK};
        state_next = S_DONE;
        if (rd.cnt == '0) begin
          res_next.status = ST_NOREF;
        end else if (op == OP_WRITE) begin
          wr.set_dirty = 1'b1;
        end else begin
          wr.we_cnt = 1'b1;
          wr.cnt    = rd.cnt - CNT_W'(1);
          if (rd.cnt == CNT_W'(1)) begin
            old_rank_next = rd_rank;
            idx_next      = '0;
            state_next    = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        // The released slot becomes newest; every newer slot moves down one.
        idx_next = idx + CW'(1);
        if (scan_cmp && ((rd_addr == slot_idx) || take)) begin
          waddr      = rd_addr;
          wr.we_rank = 1'b1;
          wrank      = (rd_addr == slot_idx) ? TOP_RANK : rd_rank - IW'(1);
        end
        if (idx == LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    best      <= best_next;
    best_rank <= best_rank_next;
    old_rank  <= old_rank_next;
    res_r     <= res_next;
    if (accept) begin
      op      <= in_op;
      dev     <= in_dev;
      blk     <= in_blk;
      slot_in <= in_slot;
    end
  end

endmodule

// ----- hdl/lru_block_buffer_cache.sv -----
// ---------------------------------------------------------------------------
// lru_block_buffer_cache
// Block buffer cache of SLOTS tagged slots with reference counts and LRU reuse.
// ---------------------------------------------------------------------------
// Usage. A request enters on in_valid/in_ready with opcode, device,
// block_number and slot; every request gives exactly one result on
// out_valid/out_ready with slot_out, hit, needs_read and status.
// The block works on one request at a time. Each request walks the slot
// memories through one shared compare unit, one slot per cycle. A get
// walks all slots for a hit, then walks them again for a free slot on a
// miss; a release that drops the count to zero walks them once to update
// the recency order; other releases and writes read only their own slot;
// io_done and a release or write with its slot out of range read none.
// After reset every slot is free and invalid with tag (0,0), the recency
// order is slot 0 oldest, and no clearing pass is needed: flags held in
// flip-flops stand in for unwritten memory entries. A result sits in an
// output register; while the receiver stalls it holds, and the block may
// take the next request but does not finish it until the register frees.
// ---------------------------------------------------------------------------
module lru_block_buffer_cache #(
  parameter int SLOTS = lbc_pkg::SLOTS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lbc_pkg::OP_W-1:0]   opcode,
  input  logic [lbc_pkg::DEV_W-1:0]  device,
  input  logic [lbc_pkg::BLK_W-1:0]  block_number,
  input  logic [lbc_pkg::SLOT_W-1:0] slot,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lbc_pkg::SLOT_W-1:0] slot_out,
  output logic                       hit,
  output logic                       needs_read,
  output logic [lbc_pkg::STAT_W-1:0] status
);
  import lbc_pkg::*;

  localparam int IW = $clog2(SLOTS);

  // Sequencer to store.
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  lbc_wr_t       wr;
  logic [IW-1:0] wrank;
  lbc_rd_t       rd;
  logic [IW-1:0] rd_rank;
  logic [IW-1:0] rd_addr;

  // Sequencer to output register.
  lbc_res_t res;
  logic     res_valid;
  logic     res_ready;

  lbc_store #(.SLOTS(SLOTS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .raddr   (raddr),
    .waddr   (waddr),
    .wr      (wr),
    .wrank   (wrank),
    .rd      (rd),
    .rd_rank (rd_rank),
    .rd_addr (rd_addr)
  );

  lbc_seq #(.SLOTS(SLOTS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (opcode),
    .in_dev    (device),
    .in_blk    (block_number),
    .in_slot   (slot),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .raddr     (raddr),
    .waddr     (waddr),
    .wr        (wr),
    .wrank     (wrank),
    .rd        (rd),
    .rd_rank   (rd_rank),
    .rd_addr   (rd_addr)
  );

  // The output register takes a new result whenever it is empty or being read.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      slot_out   <= res.slot_out;
      hit        <= res.hit;
      needs_read <= res.needs_read;
      status     <= res.status;
    end
  end

endmodule

// ----- hdl/lbc_checker.sv -----
// ---------------------------------------------------------------------------
// lbc_checker
// Port-level checks of the buffer cache, bound to the top level.
// ---------------------------------------------------------------------------
`include "lru_block_buffer_cache_assert.svh"

module lbc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lbc_pkg::SLOT_W-1:0] slot_out,
  input logic                       hit,
  input logic                       needs_read,
  input logic [lbc_pkg::STAT_W-1:0] status
);
  import lbc_pkg::*;

  // A request keeps the block busy for at least the cycle after it enters.
  `LBC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

  `LBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(slot_out) && $stable(hit) &&
                   $stable(needs_read) && $stable(status))

  `LBC_ASSERT_NOW(a_nobuf_fields, out_valid && status == ST_NOBUF,
                  slot_out == '0 && !hit && !needs_read)

  `LBC_ASSERT_NOW(a_hit_ok, out_valid && hit, status == ST_OK)

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (.*);
